[hdl/fhzc_pkg.sv]
// fhzc_pkg: shared widths, codes and controller/datapath interface types
// for the frustum and hierarchical-Z box culler. No dependencies.
`default_nettype none

package fhzc_pkg;

	localparam int CW     = 20;  // Q11.8 coordinate
	localparam int GW     = 21;  // grown box bound
	localparam int AXW    = 16;  // Q1.14 axis component
	localparam int DW     = 22;  // corner minus origin
	localparam int PW     = 38;  // delta times axis
	localparam int SW     = 40;  // dot product, Q.22
	localparam int SQW    = 44;  // squared length
	localparam int OPW    = 60;  // square root operand
	localparam int RTW    = 30;  // square root result, Q.16
	localparam int DENW   = 48;  // 512 * depth
	localparam int XW     = 58;  // depth * 256 + side * cotangent
	localparam int TADDRW = 9;
	localparam int TDEPTH = 512;

	localparam logic OP_TILE = 1'b0;
	localparam logic OP_BOX  = 1'b1;

	localparam logic [2:0] REG_ORIGIN = 3'd0;
	localparam logic [2:0] REG_VDIR   = 3'd1;
	localparam logic [2:0] REG_RIGHT  = 3'd2;
	localparam logic [2:0] REG_UP     = 3'd3;
	localparam logic [2:0] REG_SINES  = 3'd4;
	localparam logic [2:0] REG_COTS   = 3'd5;

	localparam logic [2:0] V_TILE   = 3'd0;
	localparam logic [2:0] V_NEAR   = 3'd1;
	localparam logic [2:0] V_SIDE   = 3'd2;
	localparam logic [2:0] V_TOPBOT = 3'd3;
	localparam logic [2:0] V_BEHIND = 3'd4;
	localparam logic [2:0] V_OCCL   = 3'd5;

	typedef struct packed {
		logic [59:0] origin;
		logic [47:0] vdir;
		logic [47:0] right;
		logic [47:0] up;
		logic [31:0] sines;
		logic [31:0] cots;
	} fhzc_cfg_t;

	typedef struct packed {
		logic load_box, diff, mul, sum, side, flag, div_start, tile;
		logic zmul, zsum, walk_init, walk_next;
		logic [2:0] corner;
	} fhzc_cmd_t;

	typedef struct packed {
		logic sqrt_done, div_done;
		logic r_all, l_all, u_all, d_all, neg_all, neg_any;
		logic hit, last;
	} fhzc_sts_t;

endpackage

`default_nettype wire

[hdl/fhzc_ram.sv]
// fhzc_ram: generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none

module fhzc_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hdl/fhzc_isqrt.sv]
// fhzc_isqrt: bit-serial integer square root, one result bit per cycle.
// Depends on fhzc_pkg.
`default_nettype none

module fhzc_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fhzc_pkg::OPW-1:0]   op,
	output logic                       done,
	output logic [fhzc_pkg::RTW-1:0]   root
);

	localparam int REMW = fhzc_pkg::RTW + 2;
	localparam int CNTW = $clog2(fhzc_pkg::RTW + 1);

	logic [CNTW-1:0]            cnt_q;
	logic [fhzc_pkg::OPW-1:0]   op_q;
	logic [REMW-1:0]            rem_q, rem_n;
	logic [fhzc_pkg::RTW-1:0]   root_q, root_n;
	logic [REMW+1:0]            rem2, trial;
	logic                       ge;

	always_comb begin
		rem2  = {rem_q, op_q[fhzc_pkg::OPW-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		ge    = rem2 >= trial;
		rem_n = ge ? REMW'(rem2 - trial) : REMW'(rem2);
		root_n = {root_q[fhzc_pkg::RTW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNTW'(fhzc_pkg::RTW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= op;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			op_q   <= op_q << 2;
			rem_q  <= rem_n;
			root_q <= root_n;
		end
	end

	assign done = (cnt_q == '0);
	assign root = root_q;

endmodule

`default_nettype wire

[hdl/fhzc_datapath.sv]
// fhzc_datapath: corner projection, frustum flags, tile quotient divider,
// nearest-point depth and tile walk over the max-depth store.
// Depends on fhzc_pkg, fhzc_isqrt and fhzc_ram.
`default_nettype none

module fhzc_datapath #(
	parameter int TILES_X = 32,
	parameter int TILES_Y = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fhzc_pkg::fhzc_cfg_t             cfg,
	input  logic                            twr_en,
	input  logic [fhzc_pkg::TADDRW-1:0]     tile_index,
	input  logic signed [fhzc_pkg::CW-1:0]  tile_depth,
	input  logic signed [fhzc_pkg::CW-1:0]  box_min_x,
	input  logic signed [fhzc_pkg::CW-1:0]  box_min_y,
	input  logic signed [fhzc_pkg::CW-1:0]  box_min_z,
	input  logic signed [fhzc_pkg::CW-1:0]  box_max_x,
	input  logic signed [fhzc_pkg::CW-1:0]  box_max_y,
	input  logic signed [fhzc_pkg::CW-1:0]  box_max_z,
	input  fhzc_pkg::fhzc_cmd_t             cmd,
	output fhzc_pkg::fhzc_sts_t             sts
);

	localparam int QWX  = (TILES_X > 1) ? $clog2(TILES_X) : 1;
	localparam int QWY  = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
	localparam int QD   = (QWX > QWY) ? QWX : QWY;
	localparam int DIVW = fhzc_pkg::DENW + QD + 1;
	localparam int DCW  = $clog2(QD + 1);
	localparam int AW   = fhzc_pkg::TADDRW;

	function automatic logic signed [fhzc_pkg::GW-1:0] GW_EXT(
			input logic signed [fhzc_pkg::CW-1:0] v);
		GW_EXT = {v[fhzc_pkg::CW-1], v};
	endfunction

	// configuration fields
	logic signed [fhzc_pkg::CW-1:0]  org [3];
	logic signed [fhzc_pkg::AXW-1:0] vd [3];
	logic signed [fhzc_pkg::AXW-1:0] ra [3];
	logic signed [fhzc_pkg::AXW-1:0] ua [3];
	logic [15:0] sin_h, sin_v, cot_h, cot_v;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			org[k] = cfg.origin[20*k +: 20];
			vd[k]  = cfg.vdir[16*k +: 16];
			ra[k]  = cfg.right[16*k +: 16];
			ua[k]  = cfg.up[16*k +: 16];
		end
		sin_h = cfg.sines[15:0];
		sin_v = cfg.sines[31:16];
		cot_h = cfg.cots[15:0];
		cot_v = cfg.cots[31:16];
	end

	logic signed [fhzc_pkg::GW-1:0]  lo_q [3];
	logic signed [fhzc_pkg::GW-1:0]  hi_q [3];
	logic signed [fhzc_pkg::DW-1:0]  d_q [3];
	logic signed [fhzc_pkg::PW-1:0]  pr_q [3];
	logic signed [fhzc_pkg::PW-1:0]  pu_q [3];
	logic signed [fhzc_pkg::PW-1:0]  pv_q [3];
	logic signed [fhzc_pkg::SQW-1:0] sq_q [3];
	logic signed [fhzc_pkg::SW-1:0]  sx_q, sy_q, zz_q;
	logic [45:0]                     ph_q, pv2_q;
	logic [35:0]                     cxl_q, cyl_q;
	logic signed [36:0]              cxh_q, cyh_q;
	logic signed [fhzc_pkg::XW-1:0]  xx_q, xy_q;
	logic [fhzc_pkg::DENW-1:0]       den_q;
	logic r_all_q, l_all_q, u_all_q, d_all_q, neg_all_q, neg_any_q;

	always_ff @(posedge clk) begin
		if (cmd.load_box) begin
			lo_q[0] <= GW_EXT(box_min_x) - 21'sd256;
			lo_q[1] <= GW_EXT(box_min_y) - 21'sd256;
			lo_q[2] <= GW_EXT(box_min_z) - 21'sd256;
			hi_q[0] <= GW_EXT(box_max_x) + 21'sd256;
			hi_q[1] <= GW_EXT(box_max_y) + 21'sd256;
			hi_q[2] <= GW_EXT(box_max_z) + 21'sd256;
		end
	end

	// square root of |d|^2 in Q.16
	logic [fhzc_pkg::SQW-1:0] n2;
	logic                     sqrt_done;
	logic [fhzc_pkg::RTW-1:0] nrm;

	assign n2 = $unsigned(sq_q[0]) + $unsigned(sq_q[1]) + $unsigned(sq_q[2]);

	fhzc_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sum),
		.op     ({n2, 16'b0}),
		.done   (sqrt_done),
		.root   (nrm)
	);

	logic signed [fhzc_pkg::GW-1:0] csel [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			csel[k] = cmd.corner[k] ? hi_q[k] : lo_q[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.diff) begin
				d_q[k] <= {csel[k][fhzc_pkg::GW-1], csel[k]}
					- {{2{org[k][fhzc_pkg::CW-1]}}, org[k]};
			end
			if (cmd.mul) begin
				pr_q[k] <= d_q[k] * ra[k];
				pu_q[k] <= d_q[k] * ua[k];
				pv_q[k] <= d_q[k] * vd[k];
				sq_q[k] <= d_q[k] * d_q[k];
			end
		end
		if (cmd.sum) begin
			sx_q <= pr_q[0] + pr_q[1] + pr_q[2];
			sy_q <= pu_q[0] + pu_q[1] + pu_q[2];
			zz_q <= pv_q[0] + pv_q[1] + pv_q[2];
		end
		if (cmd.side) begin
			ph_q  <= sin_h * nrm;
			pv2_q <= sin_v * nrm;
			// side * cotangent split in two halves of the side value
			cxl_q <= sx_q[19:0] * cot_h;
			cyl_q <= sy_q[19:0] * cot_v;
			cxh_q <= $signed(sx_q[39:20]) * $signed({1'b0, cot_h});
			cyh_q <= $signed(sy_q[39:20]) * $signed({1'b0, cot_v});
		end
	end

	// frustum side tests: s * 2^9 against sin * dist
	logic signed [49:0] sxe, sye, phe, pve;
	logic signed [56:0] scx, scy;
	logic r_ok, l_ok, u_ok, dn_ok, zneg;

	always_comb begin
		sxe   = $signed({sx_q[39], sx_q, 9'b0});
		sye   = $signed({sy_q[39], sy_q, 9'b0});
		phe   = $signed({4'b0, ph_q});
		pve   = $signed({4'b0, pv2_q});
		r_ok  = sxe > phe;
		l_ok  = sxe < -phe;
		u_ok  = sye > pve;
		dn_ok = sye < -pve;
		zneg  = zz_q[fhzc_pkg::SW-1];
		scx   = $signed({cxh_q, 20'b0}) + $signed({21'b0, cxl_q});
		scy   = $signed({cyh_q, 20'b0}) + $signed({21'b0, cyl_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.load_box) begin
			r_all_q   <= 1'b1;
			l_all_q   <= 1'b1;
			u_all_q   <= 1'b1;
			d_all_q   <= 1'b1;
			neg_all_q <= 1'b1;
			neg_any_q <= 1'b0;
		end else if (cmd.flag) begin
			r_all_q   <= r_all_q & r_ok;
			l_all_q   <= l_all_q & l_ok;
			u_all_q   <= u_all_q & u_ok;
			d_all_q   <= d_all_q & dn_ok;
			neg_all_q <= neg_all_q & zneg;
			neg_any_q <= neg_any_q | zneg;
		end
		if (cmd.flag) begin
			xx_q  <= $signed({scx[56], scx}) + $signed({{10{zz_q[39]}}, zz_q, 8'b0});
			xy_q  <= $signed({scy[56], scy}) + $signed({{10{zz_q[39]}}, zz_q, 8'b0});
			den_q <= {zz_q[38:0], 9'b0};
		end
	end

	// restoring divider: tile = floor(N * X / (512 * depth)), both axes at once
	logic [DIVW-1:0] rem_x_q, rem_y_q, dsh_q;
	logic [QD-1:0]   q_x_q, q_y_q;
	logic [DCW-1:0]  dcnt_q;
	logic            ge_x, ge_y;

	assign ge_x = rem_x_q >= dsh_q;
	assign ge_y = rem_y_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= DCW'(QD);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_x_q <= DIVW'(xx_q[fhzc_pkg::DENW-1:0]) * DIVW'(TILES_X);
			rem_y_q <= DIVW'(xy_q[fhzc_pkg::DENW-1:0]) * DIVW'(TILES_Y);
			dsh_q   <= DIVW'(den_q) << (QD - 1);
			q_x_q   <= '0;
			q_y_q   <= '0;
		end else if (dcnt_q != '0) begin
			rem_x_q <= ge_x ? rem_x_q - dsh_q : rem_x_q;
			rem_y_q <= ge_y ? rem_y_q - dsh_q : rem_y_q;
			q_x_q   <= (q_x_q << 1) | QD'(ge_x);
			q_y_q   <= (q_y_q << 1) | QD'(ge_y);
			dsh_q   <= dsh_q >> 1;
		end
	end

	// corner tile, clamped to the grid
	logic [QWX-1:0] tx_c;
	logic [QWY-1:0] ty_c;
	logic signed [fhzc_pkg::XW-1:0] den_s;

	always_comb begin
		den_s = $signed({10'b0, den_q});
		if (zz_q == '0) begin
			// corner in the eye plane: pick an edge by side sign
			if (sx_q > 0)       tx_c = QWX'(TILES_X - 1);
			else if (sx_q < 0)  tx_c = '0;
			else                tx_c = QWX'(TILES_X / 2);
			if (sy_q > 0)       ty_c = QWY'(TILES_Y - 1);
			else if (sy_q < 0)  ty_c = '0;
			else                ty_c = QWY'(TILES_Y / 2);
		end else begin
			if (xx_q < 0)           tx_c = '0;
			else if (xx_q >= den_s) tx_c = QWX'(TILES_X - 1);
			else                    tx_c = q_x_q[QWX-1:0];
			if (xy_q < 0)           ty_c = '0;
			else if (xy_q >= den_s) ty_c = QWY'(TILES_Y - 1);
			else                    ty_c = q_y_q[QWY-1:0];
		end
	end

	logic [QWX-1:0] tx0_q, tx1_q, tx_q;
	logic [QWY-1:0] ty0_q, ty1_q, ty_q;
	logic [AW-1:0]  row_q;

	always_ff @(posedge clk) begin
		if (cmd.load_box) begin
			tx0_q <= QWX'(TILES_X - 1);
			tx1_q <= '0;
			ty0_q <= QWY'(TILES_Y - 1);
			ty1_q <= '0;
		end else if (cmd.tile) begin
			tx0_q <= (tx_c < tx0_q) ? tx_c : tx0_q;
			tx1_q <= (tx_c > tx1_q) ? tx_c : tx1_q;
			ty0_q <= (ty_c < ty0_q) ? ty_c : ty0_q;
			ty1_q <= (ty_c > ty1_q) ? ty_c : ty1_q;
		end
	end

	// nearest box point depth
	logic signed [fhzc_pkg::GW-1:0] orge [3];
	logic signed [fhzc_pkg::GW-1:0] cl [3];
	logic signed [fhzc_pkg::DW-1:0] zd [3];
	logic signed [fhzc_pkg::PW-1:0] zp_q [3];
	logic signed [fhzc_pkg::SW-1:0] zmin_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			orge[k] = {org[k][fhzc_pkg::CW-1], org[k]};
			cl[k]   = (orge[k] > lo_q[k]) ? orge[k] : lo_q[k];
			if (cl[k] > hi_q[k]) begin
				cl[k] = hi_q[k];
			end
			zd[k] = {cl[k][fhzc_pkg::GW-1], cl[k]} - {orge[k][fhzc_pkg::GW-1], orge[k]};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.zmul) begin
				zp_q[k] <= zd[k] * vd[k];
			end
		end
		if (cmd.zsum) begin
			zmin_q <= zp_q[0] + zp_q[1] + zp_q[2];
		end
	end

	// tile walk, row major
	always_ff @(posedge clk) begin
		if (cmd.walk_init) begin
			tx_q  <= tx0_q;
			ty_q  <= ty0_q;
			row_q <= AW'(ty0_q * TILES_X);
		end else if (cmd.walk_next) begin
			if (tx_q == tx1_q) begin
				tx_q  <= tx0_q;
				ty_q  <= ty_q + 1'b1;
				row_q <= row_q + AW'(TILES_X);
			end else begin
				tx_q <= tx_q + 1'b1;
			end
		end
	end

	logic [AW-1:0]                  raddr;
	logic signed [fhzc_pkg::CW-1:0] rdep;
	logic signed [fhzc_pkg::SW-1:0] depx;

	assign raddr = row_q + AW'(tx_q);
	assign depx  = $signed({{6{rdep[fhzc_pkg::CW-1]}}, rdep, 14'b0});

	fhzc_ram #(
		.WIDTH (fhzc_pkg::CW),
		.DEPTH (fhzc_pkg::TDEPTH)
	) u_ram (
		.clk   (clk),
		.we    (twr_en),
		.waddr (tile_index),
		.wdata (tile_depth),
		.raddr (raddr),
		.rdata (rdep)
	);

	always_comb begin
		sts.sqrt_done = sqrt_done;
		sts.div_done  = (dcnt_q == '0);
		sts.r_all     = r_all_q;
		sts.l_all     = l_all_q;
		sts.u_all     = u_all_q;
		sts.d_all     = d_all_q;
		sts.neg_all   = neg_all_q;
		sts.neg_any   = neg_any_q;
		sts.hit       = !(zmin_q > depx);
		sts.last      = (tx_q == tx1_q) && (ty_q == ty1_q);
	end

`ifndef SYNTH
	a_bounds_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tile |=> (tx0_q <= tx1_q) && (ty0_q <= ty1_q))
		else $error("tile rectangle bounds out of order");

	a_walk_in_rect: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_next |=> (tx_q <= tx1_q) && (ty_q <= ty1_q) && (tx_q >= tx0_q))
		else $error("tile walk left the rectangle");
`endif

endmodule

`default_nettype wire

[hdl/fhzc_ctrl.sv]
// fhzc_ctrl: sequencer for the box test (eight corners, decision, tile walk)
// and the result register. Depends on fhzc_pkg.
`default_nettype none

module fhzc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                opcode,
	output logic                in_ready,
	output fhzc_pkg::fhzc_cmd_t cmd,
	input  fhzc_pkg::fhzc_sts_t sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                visible,
	output logic [2:0]          verdict
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_DIFF   = 5'd1;
	localparam logic [4:0] ST_MUL    = 5'd2;
	localparam logic [4:0] ST_SUM    = 5'd3;
	localparam logic [4:0] ST_SQRT   = 5'd4;
	localparam logic [4:0] ST_SIDE   = 5'd5;
	localparam logic [4:0] ST_FLAG   = 5'd6;
	localparam logic [4:0] ST_NUM    = 5'd7;
	localparam logic [4:0] ST_DIV    = 5'd8;
	localparam logic [4:0] ST_TILE   = 5'd9;
	localparam logic [4:0] ST_DECIDE = 5'd10;
	localparam logic [4:0] ST_ZMUL   = 5'd11;
	localparam logic [4:0] ST_ZSUM   = 5'd12;
	localparam logic [4:0] ST_WINIT  = 5'd13;
	localparam logic [4:0] ST_RD     = 5'd14;
	localparam logic [4:0] ST_CMP    = 5'd15;
	localparam logic [4:0] ST_EMIT   = 5'd16;

	localparam logic [2:0] LAST_CORNER = 3'd7;

	logic [4:0] state_q, state_d;
	logic [2:0] corner_q;
	logic [2:0] res_q, res_d;
	logic       out_valid_q;
	logic [2:0] verdict_q;
	logic       emit;

	assign in_ready = (state_q == ST_IDLE);
	assign emit     = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d    = state_q;
		res_d      = res_q;
		cmd        = '0;
		cmd.corner = corner_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && opcode == fhzc_pkg::OP_BOX) begin
					cmd.load_box = 1'b1;
					state_d      = ST_DIFF;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sts.sqrt_done) begin
					state_d = ST_SIDE;
				end
			end
			ST_SIDE: begin
				cmd.side = 1'b1;
				state_d  = ST_FLAG;
			end
			ST_FLAG: begin
				cmd.flag = 1'b1;
				state_d  = ST_NUM;
			end
			ST_NUM: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_TILE;
				end
			end
			ST_TILE: begin
				cmd.tile = 1'b1;
				state_d  = (corner_q == LAST_CORNER) ? ST_DECIDE : ST_DIFF;
			end
			ST_DECIDE: begin
				state_d = ST_EMIT;
				if (sts.r_all || sts.l_all) begin
					res_d = fhzc_pkg::V_SIDE;
				end else if (sts.u_all || sts.d_all) begin
					res_d = fhzc_pkg::V_TOPBOT;
				end else if (sts.neg_all) begin
					res_d = fhzc_pkg::V_BEHIND;
				end else if (sts.neg_any) begin
					res_d = fhzc_pkg::V_NEAR;
				end else begin
					state_d = ST_ZMUL;
				end
			end
			ST_ZMUL: begin
				cmd.zmul = 1'b1;
				state_d  = ST_ZSUM;
			end
			ST_ZSUM: begin
				cmd.zsum = 1'b1;
				state_d  = ST_WINIT;
			end
			ST_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d       = ST_RD;
			end
			ST_RD: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.hit) begin
					res_d   = fhzc_pkg::V_TILE;
					state_d = ST_EMIT;
				end else if (sts.last) begin
					res_d   = fhzc_pkg::V_OCCL;
					state_d = ST_EMIT;
				end else begin
					cmd.walk_next = 1'b1;
					state_d       = ST_RD;
				end
			end
			ST_EMIT: begin
				if (emit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			corner_q    <= '0;
			res_q       <= fhzc_pkg::V_TILE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.load_box) begin
				corner_q <= '0;
			end else if (cmd.tile && corner_q != LAST_CORNER) begin
				corner_q <= corner_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			verdict_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign visible   = (verdict_q == fhzc_pkg::V_TILE) || (verdict_q == fhzc_pkg::V_NEAR);

`ifndef SYNTH
	a_all_corners: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> (corner_q == LAST_CORNER))
		else $error("decision reached before all corners were processed");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_valid_q && state_q == ST_IDLE && verdict_q == $past(res_q)))
		else $error("result not loaded into the output register");
`endif

endmodule

`default_nettype wire

[hdl/frustum_hiz_box_cull_top.sv]
// Frustum and hierarchical-Z box culler. A tile write (opcode 0) stores a
// tile max depth and gives no result; a box test (opcode 1) gives one
// verdict. Boxes are processed one at a time: each of the eight corners
// goes through the bit-serial square root of the corner distance and the
// restoring tile divider, which gives D quotient bits per axis (D =
// ceil(log2(max(TILES_X, TILES_Y))), 5 by default). A box that the frustum,
// behind or near tests decide skips the tile walk; otherwise the walk reads
// the max-depth RAM once per tile visited, up to the first visible one. The
// next item is taken once the current box has moved to the output register.
// The tile store is not cleared at reset: only tiles written since reset
// may be covered by a box test.
// Depends on fhzc_pkg, fhzc_ctrl and fhzc_datapath.
`default_nettype none

module frustum_hiz_box_cull_top #(
	parameter int TILES_X = 32,
	parameter int TILES_Y = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [8:0]         tile_index,
	input  logic signed [19:0] tile_depth,
	input  logic signed [19:0] box_min_x,
	input  logic signed [19:0] box_min_y,
	input  logic signed [19:0] box_min_z,
	input  logic signed [19:0] box_max_x,
	input  logic signed [19:0] box_max_y,
	input  logic signed [19:0] box_max_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               visible,
	output logic [2:0]         verdict,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [59:0]        cfg_data
);

	fhzc_pkg::fhzc_cfg_t cfg_q;
	fhzc_pkg::fhzc_cmd_t cmd;
	fhzc_pkg::fhzc_sts_t sts;
	logic                twr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fhzc_pkg::REG_ORIGIN: cfg_q.origin <= cfg_data;
				fhzc_pkg::REG_VDIR:   cfg_q.vdir   <= cfg_data[47:0];
				fhzc_pkg::REG_RIGHT:  cfg_q.right  <= cfg_data[47:0];
				fhzc_pkg::REG_UP:     cfg_q.up     <= cfg_data[47:0];
				fhzc_pkg::REG_SINES:  cfg_q.sines  <= cfg_data[31:0];
				fhzc_pkg::REG_COTS:   cfg_q.cots   <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// tile writes go straight to the store in the accepting cycle
	assign twr_en = in_valid && in_ready && (opcode == fhzc_pkg::OP_TILE);

	fhzc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.visible   (visible),
		.verdict   (verdict)
	);

	fhzc_datapath #(
		.TILES_X (TILES_X),
		.TILES_Y (TILES_Y)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.twr_en     (twr_en),
		.tile_index (tile_index),
		.tile_depth (tile_depth),
		.box_min_x  (box_min_x),
		.box_min_y  (box_min_y),
		.box_min_z  (box_min_z),
		.box_max_x  (box_max_x),
		.box_max_y  (box_max_y),
		.box_max_z  (box_max_z),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for frustum_hiz_box_cull_top: a clocked driver and
// monitor around a built-in predictor of the frustum and hierarchical-Z culler.
// Depends on fhzc_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;

	localparam int NTX = 32;
	localparam int NTY = 16;
	localparam longint LIMIT = 6000000;

	typedef struct {
		logic              op;
		logic [8:0]        idx;
		logic signed [19:0] depth;
		logic signed [19:0] lo [3];
		logic signed [19:0] hi [3];
	} cull_req_t;

	typedef struct {
		logic       vis;
		logic [2:0] verd;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic opcode = 0;
	logic [8:0] tile_index = 0;
	logic signed [19:0] tile_depth = 0;
	logic signed [19:0] box_min_x = 0, box_min_y = 0, box_min_z = 0;
	logic signed [19:0] box_max_x = 0, box_max_y = 0, box_max_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic visible;
	logic [2:0] verdict;
	logic cfg_we = 0;
	logic [2:0] cfg_index = 0;
	logic [59:0] cfg_data = 0;

	cull_req_t req_q[$];
	verdict_t  verdict_q[$];
	logic [59:0] shadow_cfg [6];
	longint tile_store [512];
	int send_idle = 0, recv_idle = 0;
	int errors = 0, boxes_checked = 0, tile_writes = 0;
	int verdict_seen [6];
	longint cycles = 0;
	logic hold_go = 0, hold_seen = 0;
	int hold_left = 0;

	frustum_hiz_box_cull_top u_top (.*);

	always #1 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint tile_of(longint s, longint cot, longint z, longint n);
		longint num, q;
		if (z == 0) begin
			if (s > 0) return n - 1;
			if (s < 0) return 0;
			return n / 2;
		end
		num = n * (z * 256 + s * cot);
		if (num < 0) return 0;
		q = num / (2 * z * 256);
		return (q > n - 1) ? n - 1 : q;
	endfunction

	function automatic longint comp(logic [59:0] r, int k, int w);
		logic [59:0] v;
		v = r >> (w * k);
		if (w == 20) return longint'($signed(v[19:0]));
		return longint'($signed(v[15:0]));
	endfunction

	// Returns 1 with the verdict when the request yields a result.
	function automatic bit cull_predict(cull_req_t rq, output verdict_t res);
		longint org[3], vd[3], ra[3], ua[3], lo[3], hi[3], d[3];
		longint sx[8], sy[8], zz[8], nrm[8];
		longint sinh, sinv, coth, cotv, zmin, c, a, b;
		longint tx0, tx1, ty0, ty1;
		longint unsigned n2;
		bit r_all, l_all, u_all, d_all, neg_all, neg_any;
		if (rq.op == fhzc_pkg::OP_TILE) begin
			tile_store[rq.idx] = rq.depth;
			return 0;
		end
		for (int k = 0; k < 3; k++) begin
			org[k] = comp(shadow_cfg[fhzc_pkg::REG_ORIGIN], k, 20);
			vd[k] = comp(shadow_cfg[fhzc_pkg::REG_VDIR], k, 16);
			ra[k] = comp(shadow_cfg[fhzc_pkg::REG_RIGHT], k, 16);
			ua[k] = comp(shadow_cfg[fhzc_pkg::REG_UP], k, 16);
			lo[k] = longint'(rq.lo[k]) - 256;
			hi[k] = longint'(rq.hi[k]) + 256;
		end
		sinh = shadow_cfg[fhzc_pkg::REG_SINES][15:0];
		sinv = shadow_cfg[fhzc_pkg::REG_SINES][31:16];
		coth = shadow_cfg[fhzc_pkg::REG_COTS][15:0];
		cotv = shadow_cfg[fhzc_pkg::REG_COTS][31:16];
		{r_all, l_all, u_all, d_all, neg_all, neg_any} = 6'b111110;
		for (int i = 0; i < 8; i++) begin
			n2 = 0;
			for (int k = 0; k < 3; k++) begin
				d[k] = (((i >> k) & 1) ? hi[k] : lo[k]) - org[k];
				n2 += longint'(d[k] * d[k]);
			end
			nrm[i] = int_sqrt(n2 << 16);
			sx[i] = d[0] * ra[0] + d[1] * ra[1] + d[2] * ra[2];
			sy[i] = d[0] * ua[0] + d[1] * ua[1] + d[2] * ua[2];
			zz[i] = d[0] * vd[0] + d[1] * vd[1] + d[2] * vd[2];
			if (!(sx[i] * 512 > sinh * nrm[i])) r_all = 0;
			if (!(sx[i] * 512 < -(sinh * nrm[i]))) l_all = 0;
			if (!(sy[i] * 512 > sinv * nrm[i])) u_all = 0;
			if (!(sy[i] * 512 < -(sinv * nrm[i]))) d_all = 0;
			if (zz[i] < 0) neg_any = 1;
			else neg_all = 0;
		end
		res.vis = 0;
		if (r_all || l_all) begin res.verd = fhzc_pkg::V_SIDE; return 1; end
		if (u_all || d_all) begin res.verd = fhzc_pkg::V_TOPBOT; return 1; end
		if (neg_all) begin res.verd = fhzc_pkg::V_BEHIND; return 1; end
		if (neg_any) begin res.vis = 1; res.verd = fhzc_pkg::V_NEAR; return 1; end
		zmin = 0;
		for (int k = 0; k < 3; k++) begin
			c = (org[k] > lo[k]) ? org[k] : lo[k];
			if (c > hi[k]) c = hi[k];
			zmin += (c - org[k]) * vd[k];
		end
		tx0 = NTX; tx1 = -1; ty0 = NTY; ty1 = -1;
		for (int i = 0; i < 8; i++) begin
			a = tile_of(sx[i], coth, zz[i], NTX);
			b = tile_of(sy[i], cotv, zz[i], NTY);
			if (a < tx0) tx0 = a;
			if (a > tx1) tx1 = a;
			if (b < ty0) ty0 = b;
			if (b > ty1) ty1 = b;
		end
		for (longint ty = ty0; ty <= ty1; ty++)
			for (longint tx = tx0; tx <= tx1; tx++)
				if (!(zmin > tile_store[(tx + ty * NTX) & 511] * 16384)) begin
					res.vis = 1;
					res.verd = fhzc_pkg::V_TILE;
					return 1;
				end
		res.verd = fhzc_pkg::V_OCCL;
		return 1;
	endfunction

	// driver
	always @(posedge clk) begin
		cull_req_t rq;
		verdict_t  ev;
		if (!in_valid || in_ready) begin
			if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
				rq = req_q.pop_front();
				opcode <= rq.op;
				tile_index <= rq.idx;
				tile_depth <= rq.depth;
				box_min_x <= rq.lo[0]; box_min_y <= rq.lo[1]; box_min_z <= rq.lo[2];
				box_max_x <= rq.hi[0]; box_max_y <= rq.hi[1]; box_max_z <= rq.hi[2];
				if (cull_predict(rq, ev)) verdict_q.push_back(ev);
				else tile_writes++;
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_left <= 600;
			hold_seen <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t ev;
		if (out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction vis=%0d verdict=%0d", $time, visible, verdict);
			end else begin
				ev = verdict_q.pop_front();
				boxes_checked++;
				if (verdict <= fhzc_pkg::V_OCCL) verdict_seen[verdict]++;
				if (visible !== ev.vis) begin
					errors++;
					$display("%0t: visible expected %0d actual %0d", $time, ev.vis, visible);
				end
				if (verdict !== ev.verd) begin
					errors++;
					$display("%0t: verdict expected %0d actual %0d", $time, ev.verd, verdict);
				end
			end
		end
		out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout: %0d boxes outstanding", verdict_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [59:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			fhzc_pkg::REG_ORIGIN: shadow_cfg[idx] = val;
			fhzc_pkg::REG_SINES, fhzc_pkg::REG_COTS: shadow_cfg[idx] = 60'(val[31:0]);
			default: shadow_cfg[idx] = 60'(val[47:0]);
		endcase
	endtask

	task automatic set_camera(logic [59:0] o, logic [47:0] v, logic [47:0] r,
			logic [47:0] u, logic [31:0] s, logic [31:0] ct);
		write_reg(fhzc_pkg::REG_ORIGIN, o);
		write_reg(fhzc_pkg::REG_VDIR, 60'(v));
		write_reg(fhzc_pkg::REG_RIGHT, 60'(r));
		write_reg(fhzc_pkg::REG_UP, 60'(u));
		write_reg(fhzc_pkg::REG_SINES, 60'(s));
		write_reg(fhzc_pkg::REG_COTS, 60'(ct));
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic push_tile(int idx, int dep);
		cull_req_t rq;
		rq.op = fhzc_pkg::OP_TILE;
		rq.idx = 9'(idx);
		rq.depth = 20'(dep);
		for (int k = 0; k < 3; k++) begin
			rq.lo[k] = 20'($urandom);
			rq.hi[k] = 20'($urandom);
		end
		req_q.push_back(rq);
	endtask

	task automatic push_box(int x0, int y0, int z0, int x1, int y1, int z1);
		cull_req_t rq;
		rq.op = fhzc_pkg::OP_BOX;
		rq.idx = 9'($urandom);
		rq.depth = 20'($urandom);
		rq.lo[0] = 20'(x0); rq.lo[1] = 20'(y0); rq.lo[2] = 20'(z0);
		rq.hi[0] = 20'(x1); rq.hi[1] = 20'(y1); rq.hi[2] = 20'(z1);
		req_q.push_back(rq);
	endtask

	// mostly boxes in front of a forward camera; also tile writes, boxes around the origin and broken or full-range ones
	task automatic push_random(int n);
		int cx, cy, cz, sz, m;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(99);
			if (m < 20) begin
				push_tile($urandom_range(511),
					($urandom_range(3) == 0) ? int'($urandom) : int'($urandom_range(60000)));
			end else if (m < 80) begin
				cz = $urandom_range(50000, 512);
				cx = int'($urandom_range(2 * cz)) - cz;
				cy = int'($urandom_range(2 * cz)) - cz;
				sz = ($urandom_range(9) == 0) ? $urandom_range(30000) : $urandom_range(2000);
				push_box(cx - sz, cy - sz, cz - sz, cx + sz, cy + sz, cz + sz);
			end else if (m < 90) begin
				cz = int'($urandom_range(20000)) - 10000;
				push_box(-300, -300, cz - 3000, 300, 300, cz + 3000);
			end else begin
				push_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	task automatic drain();
		while (req_q.size() != 0 || verdict_q.size() != 0 || in_valid) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	localparam logic [47:0] FWD   = {16'sd16384, 16'sd0, 16'sd0};
	localparam logic [47:0] XAXIS = {16'sd0, 16'sd0, 16'sd16384};
	localparam logic [47:0] YAXIS = {16'sd0, 16'sd16384, 16'sd0};

	initial begin
		for (int i = 0; i < 6; i++) shadow_cfg[i] = 0;
		for (int i = 0; i < 512; i++) tile_store[i] = 0;
		for (int i = 0; i < 6; i++) verdict_seen[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		send_idle = 13;
		recv_idle = 68;

		// every tile written first so no box ever reads an empty entry
		set_camera(60'd0, 48'd0, 48'd0, 48'd0, 32'd0, 32'd0);
		for (int i = 0; i < 512; i++)
			push_tile(i, (i == 0) ? -524288 : (i == 511) ? 524287 : int'($urandom_range(40000)));
		push_box(0, 0, 0, 0, 0, 0);
		push_box(-524288, -524288, -524288, 524287, 524287, 524287);
		drain();

		// directed: forward camera, 90 degree field of view
		set_camera(60'd0, FWD, XAXIS, YAXIS, {16'd23170, 16'd23170}, {16'd256, 16'd256});
		push_box(-256, -256, 2560, 256, 256, 3072);        // straight ahead
		push_tile(16 + 8 * NTX, -524288);
		push_box(-256, -256, 2560, 256, 256, 3072);        // same box, tile lowered
		push_box(20000, -256, 2560, 21000, 256, 3072);     // right
		push_box(-21000, -256, 2560, -20000, 256, 3072);   // left
		push_box(-256, 20000, 2560, 256, 21000, 3072);     // top
		push_box(-256, -21000, 2560, 256, -20000, 3072);   // bottom
		push_box(-256, -256, -5000, 256, 256, -3000);      // behind
		push_box(-256, -256, -1000, 256, 256, 1000);       // straddles near plane
		push_box(-256, -256, 256, 256, 256, 2000);         // corner at zero depth
		push_box(256, 256, 3000, -256, -256, 2000);        // inverted bounds
		push_box(524287, 524287, 524287, 524287, 524287, 524287);
		push_box(-524288, -524288, -524288, -524288, -524288, -524288);
		push_tile(511, -524288);
		push_tile(0, 524287);
		push_random(30);
		drain();

		// random orientation, receiver hold-off while the sender keeps going
		set_camera(60'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom, $urandom);
		push_random(25);
		@(posedge clk);
		hold_go <= 1;
		drain();

		send_idle = 68;
		recv_idle = 13;
		// all ones: the other extreme of every register
		set_camera({60{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {32{1'b1}}, {32{1'b1}});
		push_random(25);
		drain();

		set_camera({20'($urandom_range(2000)), 20'($urandom_range(2000)), 20'd0},
			FWD, XAXIS, YAXIS, {16'd8000, 16'd12000}, {16'd1000, 16'd700});
		push_random(30);
		drain();

		send_idle = 0;
		recv_idle = 0;
		set_camera(60'd0, FWD, XAXIS, YAXIS, {16'd30000, 16'd20000}, {16'd120, 16'd300});
		push_random(40);
		drain();

		$display("checked %0d box verdicts and %0d tile writes over six camera settings",
			boxes_checked, tile_writes);
		$display("verdicts tile/near/side/topbot/behind/occluded: %0d %0d %0d %0d %0d %0d",
			verdict_seen[fhzc_pkg::V_TILE], verdict_seen[fhzc_pkg::V_NEAR],
			verdict_seen[fhzc_pkg::V_SIDE], verdict_seen[fhzc_pkg::V_TOPBOT],
			verdict_seen[fhzc_pkg::V_BEHIND], verdict_seen[fhzc_pkg::V_OCCL]);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
